>>> rtl/ordered_mac_peer_table_core_assert.svh
// Assertion macros used by the peer table sequencer (omp_seq).
`ifndef ORDERED_MAC_PEER_TABLE_CORE_ASSERT_SVH
`define ORDERED_MAC_PEER_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define OMP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("peer table assertion failed");

// next-cycle implication
`define OMP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("peer table assertion failed");

`endif

>>> rtl/omp_pkg.sv
`default_nettype none
package omp_pkg;

   localparam int TABLE_DEPTH = 32;

   localparam int OP_W      = 2;
   localparam int MAC_W     = 48;
   localparam int POS_W     = 6;
   localparam int ST_W      = 3;
   localparam int CNT_OUT_W = 6;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int LEN_W = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;

   localparam int REQ_W = 56;
   localparam int RSP_W = 112;
   localparam int PAD_W = RSP_W - (ST_W + 1 + MAC_W + 1 + MAC_W + CNT_OUT_W);

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

   localparam logic [ST_W-1:0] ST_OK      = 3'd0;
   localparam logic [ST_W-1:0] ST_BAD_POS = 3'd1;
   localparam logic [ST_W-1:0] ST_DUP     = 3'd2;
   localparam logic [ST_W-1:0] ST_FULL    = 3'd3;
   localparam logic [ST_W-1:0] ST_MISSING = 3'd4;

   // lowest field last
   typedef struct packed {
      logic [POS_W-1:0] position;
      logic [MAC_W-1:0] peer_mac;
      logic [OP_W-1:0]  opcode;
   } omp_req_type;

   typedef struct packed {
      logic [PAD_W-1:0]     pad;
      logic [CNT_OUT_W-1:0] entry_count;
      logic [MAC_W-1:0]     right_mac;
      logic                 right_valid;
      logic [MAC_W-1:0]     left_mac;
      logic                 left_valid;
      logic [ST_W-1:0]      status;
   } omp_rsp_type;

endpackage
`default_nettype wire

>>> rtl/omp_entry_ram.sv
`default_nettype none
module omp_entry_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

>>> rtl/omp_seq.sv
`default_nettype none
`include "ordered_mac_peer_table_core_assert.svh"
module omp_seq
   import omp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire omp_req_type       req,
   output logic                   req_ready,
   input  wire logic [MAC_W-1:0]  monitor_mac,
   output logic                   res_valid,
   output omp_rsp_type            res,
   input  wire logic              res_take
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SCAN     = 3'd1;
   localparam logic [2:0] S_RIGHT    = 3'd2;
   localparam logic [2:0] S_SHIFT_UP = 3'd3;
   localparam logic [2:0] S_SHIFT_DN = 3'd4;
   localparam logic [2:0] S_DONE     = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] scan_ff, scan_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [OP_W-1:0]  op_ff, op_in;
   logic [MAC_W-1:0] mac_ff, mac_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [MAC_W-1:0] prev_ff, prev_in;
   logic [ST_W-1:0]  status_ff, status_in;
   logic             lv_ff, lv_in;
   logic [MAC_W-1:0] lm_ff, lm_in;
   logic             rv_ff, rv_in;
   logic [MAC_W-1:0] rm_ff, rm_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [MAC_W-1:0] wr_data;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [MAC_W-1:0] rd_data;

   logic             acc;
   logic             hit;
   logic             in_shift;
   logic             scan_more;
   logic [LEN_W-1:0] scan_m1;
   logic [LEN_W-1:0] scan_p1;
   logic [LEN_W-1:0] pos_len;
   logic [CMP_W-1:0] pos_cmp;
   logic [CMP_W-1:0] len_cmp;

   omp_entry_ram #(
      .WIDTH (MAC_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign acc       = req_valid && req_ready;
   assign hit       = rd_vld_ff && (rd_data == mac_ff);
   assign in_shift  = (state_ff == S_SHIFT_UP) || (state_ff == S_SHIFT_DN);
   assign scan_more = (scan_ff < len_ff);
   assign scan_m1   = scan_ff - 1'b1;
   assign scan_p1   = scan_ff + 1'b1;
   assign pos_len   = LEN_W'(pos_ff);
   assign pos_cmp   = CMP_W'(req.position);
   assign len_cmp   = CMP_W'(len_ff);

   always_comb begin
      state_in  = state_ff;
      len_in    = len_ff;
      scan_in   = scan_ff;
      rd_vld_in = 1'b0;
      rd_idx_in = rd_idx_ff;
      op_in     = op_ff;
      mac_in    = mac_ff;
      pos_in    = pos_ff;
      prev_in   = rd_vld_ff ? rd_data : prev_ff;
      status_in = status_ff;
      lv_in     = lv_ff;
      lm_in     = lm_ff;
      rv_in     = rv_ff;
      rm_in     = rm_ff;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = rd_data;
      rd_en     = 1'b0;
      rd_addr   = '0;
      res_valid = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (acc) begin
               op_in     = req.opcode;
               mac_in    = req.peer_mac;
               pos_in    = req.position;
               status_in = ST_OK;
               lv_in     = 1'b0;
               lm_in     = '0;
               rv_in     = 1'b0;
               rm_in     = '0;
               scan_in   = '0;
               unique case (req.opcode)
                  OP_INSERT: begin
                     if (pos_cmp > len_cmp) begin
                        status_in = ST_BAD_POS;
                        state_in  = S_DONE;
                     end else if (req.peer_mac == monitor_mac) begin
                        status_in = ST_DUP;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  OP_REMOVE: begin
                     if (pos_cmp >= len_cmp) begin
                        status_in = ST_BAD_POS;
                        state_in  = S_DONE;
                     end else begin
                        scan_in  = LEN_W'(req.position) + 1'b1;
                        state_in = S_SHIFT_DN;
                     end
                  end
                  OP_LOOKUP: begin
                     state_in = S_SCAN;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (scan_more) begin
               rd_en     = 1'b1;
               rd_addr   = scan_ff[IDX_W-1:0];
               rd_vld_in = 1'b1;
               rd_idx_in = scan_ff[IDX_W-1:0];
               scan_in   = scan_p1;
            end
            if (hit) begin
               if (op_ff == OP_LOOKUP) begin
                  lv_in    = (rd_idx_ff != '0);
                  lm_in    = (rd_idx_ff != '0) ? prev_ff : '0;
                  state_in = S_RIGHT;
               end else begin
                  status_in = ST_DUP;
                  state_in  = S_DONE;
               end
            end else if (!scan_more && !rd_vld_ff) begin
               if (op_ff == OP_LOOKUP) begin
                  status_in = ST_MISSING;
                  state_in  = S_DONE;
               end else if (len_ff == LEN_W'(TABLE_DEPTH)) begin
                  status_in = ST_FULL;
                  state_in  = S_DONE;
               end else begin
                  scan_in  = len_ff;
                  state_in = S_SHIFT_UP;
               end
            end
         end
         S_RIGHT: begin
            // read of the entry after the hit was already in flight
            rv_in    = rd_vld_ff;
            rm_in    = rd_vld_ff ? rd_data : '0;
            state_in = S_DONE;
         end
         S_SHIFT_UP: begin
            if (scan_ff > pos_len) begin
               rd_en     = 1'b1;
               rd_addr   = scan_m1[IDX_W-1:0];
               rd_vld_in = 1'b1;
               rd_idx_in = scan_m1[IDX_W-1:0];
               scan_in   = scan_m1;
            end
            if (rd_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = rd_idx_ff + 1'b1;
               wr_data = rd_data;
            end else if (scan_ff == pos_len) begin
               wr_en    = 1'b1;
               wr_addr  = pos_len[IDX_W-1:0];
               wr_data  = mac_ff;
               len_in   = len_ff + 1'b1;
               state_in = S_DONE;
            end
         end
         S_SHIFT_DN: begin
            if (scan_more) begin
               rd_en     = 1'b1;
               rd_addr   = scan_ff[IDX_W-1:0];
               rd_vld_in = 1'b1;
               rd_idx_in = scan_ff[IDX_W-1:0];
               scan_in   = scan_p1;
            end
            if (rd_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = rd_idx_ff - 1'b1;
               wr_data = rd_data;
            end else if (!scan_more) begin
               len_in   = len_ff - 1'b1;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         len_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         len_ff    <= len_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff   <= scan_in;
      rd_idx_ff <= rd_idx_in;
      op_ff     <= op_in;
      mac_ff    <= mac_in;
      pos_ff    <= pos_in;
      prev_ff   <= prev_in;
      status_ff <= status_in;
      lv_ff     <= lv_in;
      lm_ff     <= lm_in;
      rv_ff     <= rv_in;
      rm_ff     <= rm_in;
   end

   always_comb begin
      res             = '0;
      res.status      = status_ff;
      res.left_valid  = lv_ff;
      res.left_mac    = lm_ff;
      res.right_valid = rv_ff;
      res.right_mac   = rm_ff;
      res.entry_count = CNT_OUT_W'(len_ff);
   end

   `OMP_ASSERT_IMP(a_wr_in_shift, clock, reset, wr_en, in_shift)
   `OMP_ASSERT_NEXT(a_len_hold, clock, reset, !in_shift, $stable(len_ff))
   `OMP_ASSERT_NEXT(a_busy_after_acc, clock, reset, acc, state_ff != S_IDLE)
   `OMP_ASSERT_IMP(a_len_max, clock, reset, 1'b1, len_ff <= LEN_W'(TABLE_DEPTH))
   `OMP_ASSERT_IMP(a_rd_below_len, clock, reset, rd_en, LEN_W'(rd_addr) < len_ff)

endmodule
`default_nettype wire

>>> rtl/ordered_mac_peer_table_core.sv
// Lookup scans the entries; insert scans them and then shifts entries up to open the slot;
// remove shifts the later entries down; rejects at accept and opcode 3 go straight to the result.
// Throughput: one item at a time; the entry RAM walk (one entry per cycle) sets it.
// The next item can be accepted in the cycle after the result moves to the output register.
// Reset: synchronous; clears the entry count, monitor address and control state.
// Table RAM contents are not cleared; only entries below the count are read.
`default_nettype none
module ordered_mac_peer_table_core
   import omp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   // opcode[1:0], peer_mac[49:2], position[55:50]
   input  wire logic [REQ_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   // status[2:0], left_valid[3], left_mac[51:4], right_valid[52], right_mac[100:53],
   // entry_count[106:101], zero pad[111:107]
   output logic      [RSP_W-1:0] rsp_tdata,
   input  wire logic             csr_wr_en,
   input  wire logic [MAC_W-1:0] csr_wr_data
);

   logic [MAC_W-1:0] monitor_ff, monitor_in;
   logic             rsp_valid_ff, rsp_valid_in;
   omp_rsp_type      rsp_data_ff, rsp_data_in;

   omp_req_type req;
   omp_rsp_type res;
   logic        res_valid;
   logic        res_take;

   assign req = omp_req_type'(req_tdata);

   omp_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req         (req),
      .req_ready   (req_tready),
      .monitor_mac (monitor_ff),
      .res_valid   (res_valid),
      .res         (res),
      .res_take    (res_take)
   );

   assign res_take    = res_valid && (!rsp_valid_ff || rsp_tready);
   assign monitor_in  = csr_wr_en ? csr_wr_data : monitor_ff;
   assign rsp_data_in = res_take ? res : rsp_data_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         monitor_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         monitor_ff   <= monitor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire
